/* sv/stbg_pkg.sv */
package stbg_pkg;

  localparam int DUR_W = 12;
  localparam int AMP_IN_W = 16;
  localparam int AMP_W = 13;
  localparam int BDUR_W = 11;
  localparam int SMP_W = 14;
  localparam int STATUS_W = 2;
  localparam int OP_W = 2;
  localparam int ELAPSED_W = 12;
  localparam int BUDGET_W = 7;
  localparam int DONE_W = 16;

  localparam logic [DUR_W-1:0] MIN_DUR = 12'd16;
  localparam logic [DUR_W-1:0] MAX_DUR = 12'd2000;
  localparam logic [AMP_IN_W-1:0] MAX_AMP = 16'd6000;
  localparam logic [AMP_W-1:0] DEF_AMP = 13'd1200;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 12'd4095;

  // The chunk budget is ceil(duration / 16), independent of the chunk time.
  localparam logic [DUR_W-1:0] BUDGET_ROUND = 12'd15;
  localparam int BUDGET_SHIFT = 4;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_BAD_ARG     = 2'd1,
    ST_WRONG_STATE = 2'd2
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic [DUR_W-1:0]    duration;
    logic [AMP_IN_W-1:0] amplitude;
  } req_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    sample_valid;
    logic                    chunk_last;
    status_t                 status;
    logic                    playing;
    logic [DONE_W-1:0]       chunks_played;
  } rsp_t;

endpackage

/* sv/square_tone_burst_generator_unit.sv */
// Square-wave test-tone burst source. A start beat arms a burst of at most
// ceil(duration / 16) chunks; each sample beat then returns the next square-wave sample,
// and a stop beat cancels the burst. Every request beat yields exactly one response
// beat. A request is held in an input register and resolved against the burst state by
// single-pass logic into a response register, so the block takes one beat every clock
// cycle unless the response register is stalled. The response register only holds the
// request side back while it is itself stalled.
module square_tone_burst_generator_unit
  import stbg_pkg::*;
#(
  parameter int CHUNK_SAMPLES = 256,
  parameter int TOGGLE_SAMPLES = 18,
  parameter int CHUNK_TIME_MS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic item_valid;
  req_t item;
  logic rsp_free;
  logic fire;
  rsp_t rsp_next;

  assign rsp_free = !rsp_valid || !rsp_stall;
  assign fire = item_valid && rsp_free;
  assign req_stall = item_valid && !rsp_free;

  stbg_core #(
    .CHUNK_SAMPLES(CHUNK_SAMPLES),
    .TOGGLE_SAMPLES(TOGGLE_SAMPLES),
    .CHUNK_TIME_MS(CHUNK_TIME_MS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .fire(fire),
    .req(item),
    .rsp_next(rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        item_valid <= 1'b1;
      end else if (fire) begin
        item_valid <= 1'b0;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item <= req;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* sv/stbg_core.sv */
module stbg_core
  import stbg_pkg::*;
#(
  parameter int CHUNK_SAMPLES = 256,
  parameter int TOGGLE_SAMPLES = 18,
  parameter int CHUNK_TIME_MS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  req_t req,
  output rsp_t rsp_next
);

  localparam int SC_W = (CHUNK_SAMPLES > 1) ? $clog2(CHUNK_SAMPLES) : 1;
  localparam int HC_W = (TOGGLE_SAMPLES > 1) ? $clog2(TOGGLE_SAMPLES) : 1;

  logic                 active, active_next;
  logic [AMP_W-1:0]     burst_amplitude, burst_amplitude_next;
  logic [BDUR_W-1:0]    burst_duration, burst_duration_next;
  logic [ELAPSED_W-1:0] elapsed_time, elapsed_time_next;
  logic [BUDGET_W-1:0]  chunks_left, chunks_left_next;
  logic [DONE_W-1:0]    chunks_done, chunks_done_next;
  logic [HC_W-1:0]      half_counter, half_counter_next;
  logic                 polarity, polarity_next;
  logic [SC_W-1:0]      sample_in_chunk, sample_in_chunk_next;

  logic                 bad_arg;
  logic [DUR_W-1:0]     budget_sum;
  logic [ELAPSED_W:0]   elapsed_sum;
  logic [ELAPSED_W-1:0] elapsed_sat;
  logic [BUDGET_W-1:0]  chunks_left_dec;
  logic [SMP_W-1:0]     amp_ext;
  logic                 half_end;
  logic                 chunk_end;

  assign bad_arg = (req.duration < MIN_DUR) || (req.duration > MAX_DUR) ||
                   (req.amplitude > MAX_AMP);
  assign budget_sum = req.duration + BUDGET_ROUND;
  assign elapsed_sum = {1'b0, elapsed_time} + (ELAPSED_W + 1)'(CHUNK_TIME_MS);
  assign elapsed_sat = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
  assign chunks_left_dec = (chunks_left != '0) ? (chunks_left - 1'b1) : '0;
  assign amp_ext = {1'b0, burst_amplitude};
  assign half_end = (half_counter == HC_W'(TOGGLE_SAMPLES - 1));
  assign chunk_end = (sample_in_chunk == SC_W'(CHUNK_SAMPLES - 1));

  always_comb begin
    active_next = active;
    burst_amplitude_next = burst_amplitude;
    burst_duration_next = burst_duration;
    elapsed_time_next = elapsed_time;
    chunks_left_next = chunks_left;
    chunks_done_next = chunks_done;
    half_counter_next = half_counter;
    polarity_next = polarity;
    sample_in_chunk_next = sample_in_chunk;

    rsp_next.sample = '0;
    rsp_next.sample_valid = 1'b0;
    rsp_next.chunk_last = 1'b0;
    rsp_next.status = ST_OK;

    unique case (req.op)
      OP_SAMPLE: begin
        if (active) begin
          rsp_next.sample = polarity ? $signed(SMP_W'(0) - amp_ext) : $signed(amp_ext);
          rsp_next.sample_valid = 1'b1;
          if (half_end) begin
            half_counter_next = '0;
            polarity_next = ~polarity;
          end else begin
            half_counter_next = half_counter + 1'b1;
          end
          if (chunk_end) begin
            rsp_next.chunk_last = 1'b1;
            sample_in_chunk_next = '0;
            chunks_done_next = chunks_done + 1'b1;
            chunks_left_next = chunks_left_dec;
            elapsed_time_next = elapsed_sat;
            if ((chunks_left_dec == '0) || (elapsed_sat >= {1'b0, burst_duration})) begin
              active_next = 1'b0;
            end
          end else begin
            sample_in_chunk_next = sample_in_chunk + 1'b1;
          end
        end
      end
      OP_START: begin
        if (bad_arg) begin
          rsp_next.status = ST_BAD_ARG;
        end else if (active) begin
          rsp_next.status = ST_WRONG_STATE;
        end else begin
          active_next = 1'b1;
          burst_amplitude_next = (req.amplitude == '0) ? DEF_AMP : req.amplitude[AMP_W-1:0];
          burst_duration_next = req.duration[BDUR_W-1:0];
          elapsed_time_next = '0;
          chunks_left_next = BUDGET_W'(budget_sum >> BUDGET_SHIFT);
          chunks_done_next = '0;
          half_counter_next = '0;
          polarity_next = 1'b0;
          sample_in_chunk_next = '0;
        end
      end
      OP_STOP: begin
        if (!active) begin
          rsp_next.status = ST_WRONG_STATE;
        end else begin
          active_next = 1'b0;
          chunks_left_next = '0;
          half_counter_next = '0;
          polarity_next = 1'b0;
          sample_in_chunk_next = '0;
        end
      end
      default: begin
        rsp_next.status = ST_BAD_ARG;
      end
    endcase

    rsp_next.playing = active_next;
    rsp_next.chunks_played = chunks_done_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      burst_amplitude <= '0;
      burst_duration <= '0;
      elapsed_time <= '0;
      chunks_left <= '0;
      chunks_done <= '0;
      half_counter <= '0;
      polarity <= 1'b0;
      sample_in_chunk <= '0;
    end else if (fire) begin
      active <= active_next;
      burst_amplitude <= burst_amplitude_next;
      burst_duration <= burst_duration_next;
      elapsed_time <= elapsed_time_next;
      chunks_left <= chunks_left_next;
      chunks_done <= chunks_done_next;
      half_counter <= half_counter_next;
      polarity <= polarity_next;
      sample_in_chunk <= sample_in_chunk_next;
    end
  end

endmodule

/* sim/tb_square_tone_burst_generator_unit.sv */
`timescale 1ns / 1ps

module tb_square_tone_burst_generator_unit;
  import stbg_pkg::*;

  localparam int CHUNK_SAMPLES = 256;
  localparam int TOGGLE_SAMPLES = 18;
  localparam int CHUNK_TIME_MS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 360;
  localparam int MAX_REPORTS = 60;
  localparam op_t OP_UNUSED = op_t'(2'd3);

  typedef struct packed {
    req_t stim;
    logic typed;
    rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  logic tone_active;
  logic [AMP_W-1:0] tone_amp;
  logic [BDUR_W-1:0] tone_dur;
  logic [ELAPSED_W-1:0] tone_elapsed;
  logic [BUDGET_W-1:0] budget_left;
  logic [DONE_W-1:0] chunks_done;
  int half_count;
  int chunk_pos;
  logic polarity;

  rsp_t pending_tone_results[$];
  rsp_t oldest_result;
  dir_row_t dir_rows[$];

  int send_idle_pct;
  int rcv_idle_pct;
  int cycles;
  int errors;
  int beats_sent;
  int samples_seen;
  int chunk_ends_seen;
  int bursts_finished;

  square_tone_burst_generator_unit #(
    .CHUNK_SAMPLES(CHUNK_SAMPLES),
    .TOGGLE_SAMPLES(TOGGLE_SAMPLES),
    .CHUNK_TIME_MS(CHUNK_TIME_MS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void phase_clear();
    half_count = 0;
    polarity = 1'b0;
    chunk_pos = 0;
  endfunction

  function automatic rsp_t tone_step(req_t r);
    rsp_t res;
    int scratch;
    res = '0;
    res.status = ST_OK;
    case (r.op)
      OP_SAMPLE: begin
        if (tone_active) begin
          res.sample = polarity ? -$signed({1'b0, tone_amp}) : $signed({1'b0, tone_amp});
          res.sample_valid = 1'b1;
          half_count++;
          if (half_count >= TOGGLE_SAMPLES) begin
            half_count = 0;
            polarity = ~polarity;
          end
          chunk_pos++;
          if (chunk_pos >= CHUNK_SAMPLES) begin
            res.chunk_last = 1'b1;
            chunk_pos = 0;
            chunks_done++;
            if (budget_left != 0) budget_left--;
            scratch = int'(tone_elapsed) + CHUNK_TIME_MS;
            tone_elapsed = (scratch > ELAPSED_MAX) ? ELAPSED_MAX : scratch[ELAPSED_W-1:0];
            if (budget_left == 0 || tone_elapsed >= tone_dur) tone_active = 1'b0;
          end
        end
      end
      OP_START: begin
        if (r.duration < MIN_DUR || r.duration > MAX_DUR || r.amplitude > MAX_AMP) begin
          res.status = ST_BAD_ARG;
        end else if (tone_active) begin
          res.status = ST_WRONG_STATE;
        end else begin
          tone_active = 1'b1;
          tone_amp = (r.amplitude == 0) ? DEF_AMP : r.amplitude[AMP_W-1:0];
          tone_dur = r.duration[BDUR_W-1:0];
          tone_elapsed = '0;
          scratch = (int'(r.duration) + 15) / 16;
          budget_left = scratch[BUDGET_W-1:0];
          chunks_done = '0;
          phase_clear();
        end
      end
      OP_STOP: begin
        if (!tone_active) begin
          res.status = ST_WRONG_STATE;
        end else begin
          tone_active = 1'b0;
          budget_left = '0;
          phase_clear();
        end
      end
      default: res.status = ST_BAD_ARG;
    endcase
    res.playing = tone_active;
    res.chunks_played = chunks_done;
    return res;
  endfunction

  function automatic req_t mk_req(op_t op, int dur, int amp);
    req_t r;
    r.op = op;
    r.duration = dur[DUR_W-1:0];
    r.amplitude = amp[AMP_IN_W-1:0];
    return r;
  endfunction

  function automatic rsp_t mk_rsp(int smp, bit valid, bit last, status_t st, bit playing,
                                  int chunks);
    rsp_t r;
    r.sample = smp[SMP_W-1:0];
    r.sample_valid = valid;
    r.chunk_last = last;
    r.status = st;
    r.playing = playing;
    r.chunks_played = chunks[DONE_W-1:0];
    return r;
  endfunction

  function automatic req_t noise_beat();
    int amp;
    amp = $urandom_range(1) ? $urandom_range(65535) : $urandom_range(6000);
    return mk_req(op_t'($urandom_range(3)), $urandom_range(4095), amp);
  endfunction

  function automatic req_t sample_beat();
    return mk_req(OP_SAMPLE, $urandom_range(4095), $urandom_range(65535));
  endfunction

  task automatic add_row(req_t stim, bit typed, rsp_t want);
    dir_row_t row;
    row.stim = stim;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  task automatic report_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR cycle %0d: %s", cycles, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  task automatic send_beat(req_t r, bit typed = 1'b0, rsp_t want = '0);
    rsp_t predicted;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    predicted = tone_step(r);
    pending_tone_results.push_back(typed ? want : predicted);
    beats_sent++;
  endtask

  task automatic wait_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_tone_results.size() != 0);
  endtask

  task automatic mixed_sample();
    if ($urandom_range(99) < 4) send_beat(noise_beat());
    else send_beat(sample_beat());
  endtask

  task automatic run_phase(int target);
    int first;
    int dur;
    int amp;
    int n;
    first = beats_sent;
    while (beats_sent - first < target) begin
      if ($urandom_range(99) < 15) begin
        send_beat(noise_beat());
      end else begin
        case ($urandom_range(9))
          0: dur = $urandom_range(1) ? int'(MIN_DUR) : int'(MAX_DUR);
          1, 2: dur = $urandom_range(int'(MAX_DUR), 41);
          default: dur = $urandom_range(40, 16);
        endcase
        case ($urandom_range(9))
          0, 1: amp = 0;
          2: amp = int'(MAX_AMP);
          3: amp = 1;
          default: amp = $urandom_range(int'(MAX_AMP));
        endcase
        send_beat(mk_req(OP_START, dur, amp));
        if (dur <= 48 && $urandom_range(1)) begin
          while (tone_active && beats_sent - first < target) mixed_sample();
        end else begin
          n = $urandom_range(300, 1);
          repeat (n) begin
            if (beats_sent - first < target) mixed_sample();
          end
          if ($urandom_range(99) < 70)
            send_beat(mk_req(OP_STOP, $urandom_range(4095), $urandom_range(65535)));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_square_tone_burst_generator_unit: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_tone_results.size() == 0) begin
        report_error($sformatf("response beat with nothing expected: %p", rsp));
      end else begin
        oldest_result = pending_tone_results.pop_front();
        check_field("sample", int'($signed(rsp.sample)), int'($signed(oldest_result.sample)));
        check_field("sample_valid", rsp.sample_valid, oldest_result.sample_valid);
        check_field("chunk_last", rsp.chunk_last, oldest_result.chunk_last);
        check_field("status", int'(rsp.status), int'(oldest_result.status));
        check_field("playing", rsp.playing, oldest_result.playing);
        check_field("chunks_played", rsp.chunks_played, oldest_result.chunks_played);
        if (oldest_result.sample_valid) samples_seen++;
        if (oldest_result.chunk_last) chunk_ends_seen++;
        if (oldest_result.chunk_last && !oldest_result.playing) bursts_finished++;
      end
    end
    rsp_stall <= !rst && ($urandom_range(99) < rcv_idle_pct);
  end

  initial begin
    tone_active = 1'b0;
    tone_amp = '0;
    tone_dur = '0;
    tone_elapsed = '0;
    budget_left = '0;
    chunks_done = '0;
    phase_clear();
    cycles = 0;
    errors = 0;
    beats_sent = 0;
    samples_seen = 0;
    chunk_ends_seen = 0;
    bursts_finished = 0;
    send_idle_pct = 0;
    rcv_idle_pct = 0;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    rst = 1'b1;

    add_row(mk_req(OP_SAMPLE, 0, 0), 1, mk_rsp(0, 0, 0, ST_OK, 0, 0));
    add_row(mk_req(OP_STOP, 4095, 65535), 1, mk_rsp(0, 0, 0, ST_WRONG_STATE, 0, 0));
    add_row(mk_req(OP_UNUSED, 4095, 65535), 1, mk_rsp(0, 0, 0, ST_BAD_ARG, 0, 0));
    add_row(mk_req(OP_START, 15, 100), 1, mk_rsp(0, 0, 0, ST_BAD_ARG, 0, 0));
    add_row(mk_req(OP_START, 2001, 100), 1, mk_rsp(0, 0, 0, ST_BAD_ARG, 0, 0));
    add_row(mk_req(OP_START, 16, 6001), 1, mk_rsp(0, 0, 0, ST_BAD_ARG, 0, 0));
    add_row(mk_req(OP_START, 4095, 65535), 1, mk_rsp(0, 0, 0, ST_BAD_ARG, 0, 0));
    add_row(mk_req(OP_START, 0, 0), 1, mk_rsp(0, 0, 0, ST_BAD_ARG, 0, 0));
    add_row(mk_req(OP_START, 16, 0), 1, mk_rsp(0, 0, 0, ST_OK, 1, 0));
    add_row(mk_req(OP_START, 100, 50), 1, mk_rsp(0, 0, 0, ST_WRONG_STATE, 1, 0));
    add_row(mk_req(OP_START, 2001, 50), 1, mk_rsp(0, 0, 0, ST_BAD_ARG, 1, 0));
    add_row(mk_req(OP_SAMPLE, 4095, 65535), 1, mk_rsp(1200, 1, 0, ST_OK, 1, 0));
    add_row(mk_req(OP_SAMPLE, 0, 0), 0, '0);
    add_row(mk_req(OP_STOP, 0, 0), 1, mk_rsp(0, 0, 0, ST_OK, 0, 0));
    add_row(mk_req(OP_SAMPLE, 0, 0), 1, mk_rsp(0, 0, 0, ST_OK, 0, 0));
    add_row(mk_req(OP_START, 2000, 6000), 1, mk_rsp(0, 0, 0, ST_OK, 1, 0));
    add_row(mk_req(OP_SAMPLE, 0, 0), 1, mk_rsp(6000, 1, 0, ST_OK, 1, 0));
    add_row(mk_req(OP_STOP, 4095, 65535), 1, mk_rsp(0, 0, 0, ST_OK, 0, 0));
    add_row(mk_req(OP_START, 17, 1), 1, mk_rsp(0, 0, 0, ST_OK, 1, 0));
    add_row(mk_req(OP_SAMPLE, 0, 0), 1, mk_rsp(1, 1, 0, ST_OK, 1, 0));
    add_row(mk_req(OP_UNUSED, 0, 0), 1, mk_rsp(0, 0, 0, ST_BAD_ARG, 1, 0));
    add_row(mk_req(OP_SAMPLE, 0, 0), 0, '0);
    add_row(mk_req(OP_STOP, 0, 0), 0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_beat(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    wait_drain();

    send_idle_pct = 20;
    rcv_idle_pct = 74;
    run_phase(PHASE_ITEMS / 2);
    wait_drain();
    run_phase(PHASE_ITEMS / 2);
    wait_drain();

    send_idle_pct = 74;
    rcv_idle_pct = 20;
    run_phase(PHASE_ITEMS);
    wait_drain();

    send_idle_pct = 0;
    rcv_idle_pct = 0;
    run_phase(PHASE_ITEMS);
    wait_drain();

    repeat (8) @(posedge clk);
    if (pending_tone_results.size() != 0)
      report_error($sformatf("%0d responses never arrived", pending_tone_results.size()));

    $display("Run covered %0d request beats, %0d tone samples and %0d chunk ends.",
             beats_sent, samples_seen, chunk_ends_seen);
    $display("%0d bursts ran out on their own; %0d mismatches were found.",
             bursts_finished, errors);
    if (errors == 0) begin
      $display("tb_square_tone_burst_generator_unit: PASS");
    end else begin
      $display("tb_square_tone_burst_generator_unit: FAIL");
    end
    $finish;
  end

endmodule
